FILE: hdl/pidsc_pkg.sv
package pidsc_pkg;

    localparam int VW    = 32;
    localparam int FB    = 16;
    localparam int DT_W  = FB + 1;
    localparam int LIM_W = VW - 1;
    localparam int PW    = 2 * VW;
    localparam int MW    = PW - FB;
    localparam int MASK_W = 6;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [DT_W-1:0] DT_RESET = DT_W'(((1 << FB) + 25) / 50);

    typedef logic signed [VW-1:0] t_val;

    localparam t_val VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] MAG_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [PW-1:0] RND_HALF = PW'(1) << (FB - 1);

    localparam int EN_P   = 0;
    localparam int EN_D   = 1;
    localparam int EN_I   = 2;
    localparam int EN_LIM = 3;
    localparam int EN_MIN = 4;
    localparam int EN_MAX = 5;

    typedef enum logic [1:0] {
        REQ_READING = 2'd0,
        REQ_TARGET  = 2'd1,
        REQ_TICK    = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_DT      = 3'd3,
        REG_ILIM    = 3'd4,
        REG_OUT_MIN = 3'd5,
        REG_OUT_MAX = 3'd6,
        REG_MASK    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ERR,
        OP_DIFF,
        OP_MUL,
        OP_RND,
        OP_ACC,
        OP_INT_ADD,
        OP_INT_LIM,
        OP_CLAMP,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        MSEL_KP_ERR,
        MSEL_KD_DIFF,
        MSEL_ERR_DT,
        MSEL_KI_INT
    } t_msel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_PMUL,
        S_PRND,
        S_PACC,
        S_DIFF,
        S_DMUL,
        S_DRND,
        S_DACC,
        S_IMUL,
        S_IRND,
        S_IADD,
        S_ILIM,
        S_KMUL,
        S_KRND,
        S_KACC,
        S_CLAMP,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        logic  ld_reading;
        logic  ld_target;
        logic  en_min;
        logic  en_max;
    } t_cmd;

    typedef struct packed {
        logic have_both;
        logic out_free;
    } t_stat;

    typedef struct packed {
        t_val             kp;
        t_val             ki;
        t_val             kd_scaled;
        logic [DT_W-1:0]  dt_step;
        logic [LIM_W-1:0] i_limit;
        t_val             out_min;
        t_val             out_max;
    } t_cfg;

    typedef struct packed {
        t_val v;
        logic s;
    } t_satv;

    function automatic t_satv sat_add(t_val a, t_val b, logic sub);
        logic signed [VW:0] s;
        t_satv r;
        if (sub) begin
            s = {a[VW-1], a} - {b[VW-1], b};
        end else begin
            s = {a[VW-1], a} + {b[VW-1], b};
        end
        if (s[VW] != s[VW-1]) begin
            r.v = s[VW] ? VMIN : VMAX;
            r.s = 1'b1;
        end else begin
            r.v = s[VW-1:0];
            r.s = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] mag(t_val x);
        logic [VW-1:0] u;
        u = x;
        return x[VW-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

FILE: hdl/pidsc_ctrl.sv
module pidsc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [1:0]                    i_req_type,
    input  logic [pidsc_pkg::MASK_W-1:0]  i_mask,
    input  pidsc_pkg::t_stat              i_stat,
    output logic                          o_in_ready,
    output pidsc_pkg::t_cmd               o_cmd
);

    pidsc_pkg::t_state r_state, n_state;
    pidsc_pkg::t_state after_p, after_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        after_d = i_mask[pidsc_pkg::EN_I] ? pidsc_pkg::S_IMUL : pidsc_pkg::S_CLAMP;
        after_p = i_mask[pidsc_pkg::EN_D] ? pidsc_pkg::S_DIFF : after_d;
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.op         = pidsc_pkg::OP_NOP;
        o_cmd.msel       = pidsc_pkg::MSEL_KP_ERR;
        o_cmd.ld_reading = 1'b0;
        o_cmd.ld_target  = 1'b0;
        o_cmd.en_min     = i_mask[pidsc_pkg::EN_MIN];
        o_cmd.en_max     = i_mask[pidsc_pkg::EN_MAX];
        case (r_state)
            pidsc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (pidsc_pkg::t_req'(i_req_type))
                        pidsc_pkg::REQ_READING: o_cmd.ld_reading = 1'b1;
                        pidsc_pkg::REQ_TARGET:  o_cmd.ld_target = 1'b1;
                        pidsc_pkg::REQ_TICK: begin
                            if (i_stat.have_both) begin
                                n_state = pidsc_pkg::S_ERR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pidsc_pkg::S_ERR: begin
                o_cmd.op = pidsc_pkg::OP_ERR;
                n_state  = i_mask[pidsc_pkg::EN_P] ? pidsc_pkg::S_PMUL : after_p;
            end
            pidsc_pkg::S_PMUL: begin
                o_cmd.op   = pidsc_pkg::OP_MUL;
                o_cmd.msel = pidsc_pkg::MSEL_KP_ERR;
                n_state    = pidsc_pkg::S_PRND;
            end
            pidsc_pkg::S_PRND: begin
                o_cmd.op = pidsc_pkg::OP_RND;
                n_state  = pidsc_pkg::S_PACC;
            end
            pidsc_pkg::S_PACC: begin
                o_cmd.op = pidsc_pkg::OP_ACC;
                n_state  = after_p;
            end
            pidsc_pkg::S_DIFF: begin
                o_cmd.op = pidsc_pkg::OP_DIFF;
                n_state  = pidsc_pkg::S_DMUL;
            end
            pidsc_pkg::S_DMUL: begin
                o_cmd.op   = pidsc_pkg::OP_MUL;
                o_cmd.msel = pidsc_pkg::MSEL_KD_DIFF;
                n_state    = pidsc_pkg::S_DRND;
            end
            pidsc_pkg::S_DRND: begin
                o_cmd.op = pidsc_pkg::OP_RND;
                n_state  = pidsc_pkg::S_DACC;
            end
            pidsc_pkg::S_DACC: begin
                o_cmd.op = pidsc_pkg::OP_ACC;
                n_state  = after_d;
            end
            pidsc_pkg::S_IMUL: begin
                o_cmd.op   = pidsc_pkg::OP_MUL;
                o_cmd.msel = pidsc_pkg::MSEL_ERR_DT;
                n_state    = pidsc_pkg::S_IRND;
            end
            pidsc_pkg::S_IRND: begin
                o_cmd.op = pidsc_pkg::OP_RND;
                n_state  = pidsc_pkg::S_IADD;
            end
            pidsc_pkg::S_IADD: begin
                o_cmd.op = pidsc_pkg::OP_INT_ADD;
                n_state  = pidsc_pkg::S_ILIM;
            end
            pidsc_pkg::S_ILIM: begin
                if (i_mask[pidsc_pkg::EN_LIM]) begin
                    o_cmd.op = pidsc_pkg::OP_INT_LIM;
                end
                n_state = pidsc_pkg::S_KMUL;
            end
            pidsc_pkg::S_KMUL: begin
                o_cmd.op   = pidsc_pkg::OP_MUL;
                o_cmd.msel = pidsc_pkg::MSEL_KI_INT;
                n_state    = pidsc_pkg::S_KRND;
            end
            pidsc_pkg::S_KRND: begin
                o_cmd.op = pidsc_pkg::OP_RND;
                n_state  = pidsc_pkg::S_KACC;
            end
            pidsc_pkg::S_KACC: begin
                o_cmd.op = pidsc_pkg::OP_ACC;
                n_state  = pidsc_pkg::S_CLAMP;
            end
            pidsc_pkg::S_CLAMP: begin
                o_cmd.op = pidsc_pkg::OP_CLAMP;
                n_state  = pidsc_pkg::S_OUT;
            end
            pidsc_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = pidsc_pkg::OP_OUT;
                    n_state  = pidsc_pkg::S_IDLE;
                end
            end
            default: n_state = pidsc_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: hdl/pidsc_dp.sv
module pidsc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pidsc_pkg::t_cmd       i_cmd,
    input  pidsc_pkg::t_cfg       i_cfg,
    input  pidsc_pkg::t_val       i_speed_value,
    input  logic                  i_out_ready,
    output pidsc_pkg::t_stat      o_stat,
    output logic                  o_out_valid,
    output pidsc_pkg::t_val       o_control_value,
    output logic                  o_output_clamped
);

    pidsc_pkg::t_val r_reading, r_target;
    logic            r_have_reading, r_have_target;
    pidsc_pkg::t_val r_int, r_last_err;
    pidsc_pkg::t_val r_error, r_term, r_ctl;
    logic            r_sat;
    logic [pidsc_pkg::PW-1:0] r_prod;
    logic            r_neg;
    logic            r_out_valid;
    pidsc_pkg::t_val r_out_ctl;
    logic            r_out_clamped;

    pidsc_pkg::t_val mul_a, mul_b;
    logic [pidsc_pkg::PW-1:0] rnd_sum;
    logic [pidsc_pkg::MW-1:0] rnd_mag;
    logic            rnd_hi;
    logic [pidsc_pkg::VW-1:0] rnd_lo;
    pidsc_pkg::t_satv rnd_res;
    pidsc_pkg::t_satv err_res, diff_res, acc_res, int_res;
    pidsc_pkg::t_val lim_pos, lim_neg, lim_val;
    pidsc_pkg::t_val clamp_val;
    logic            clamp_hit;
    logic            out_free;

    always_comb begin
        case (i_cmd.msel)
            pidsc_pkg::MSEL_KP_ERR: begin
                mul_a = i_cfg.kp;
                mul_b = r_error;
            end
            pidsc_pkg::MSEL_KD_DIFF: begin
                mul_a = i_cfg.kd_scaled;
                mul_b = r_term;
            end
            pidsc_pkg::MSEL_ERR_DT: begin
                mul_a = r_error;
                mul_b = pidsc_pkg::t_val'({{(pidsc_pkg::VW - pidsc_pkg::DT_W){1'b0}},
                                           i_cfg.dt_step});
            end
            pidsc_pkg::MSEL_KI_INT: begin
                mul_a = i_cfg.ki;
                mul_b = r_int;
            end
            default: begin
                mul_a = i_cfg.kp;
                mul_b = r_error;
            end
        endcase
    end

    always_comb begin
        rnd_sum = r_prod + pidsc_pkg::RND_HALF;
        rnd_mag = rnd_sum[pidsc_pkg::PW-1:pidsc_pkg::FB];
        rnd_hi  = |rnd_mag[pidsc_pkg::MW-1:pidsc_pkg::VW];
        rnd_lo  = rnd_mag[pidsc_pkg::VW-1:0];
        if (r_neg) begin
            if (rnd_hi || rnd_lo > pidsc_pkg::MAG_MIN) begin
                rnd_res.v = pidsc_pkg::VMIN;
                rnd_res.s = 1'b1;
            end else begin
                rnd_res.v = pidsc_pkg::t_val'(~rnd_lo + 1'b1);
                rnd_res.s = 1'b0;
            end
        end else begin
            if (rnd_hi || rnd_lo[pidsc_pkg::VW-1]) begin
                rnd_res.v = pidsc_pkg::VMAX;
                rnd_res.s = 1'b1;
            end else begin
                rnd_res.v = pidsc_pkg::t_val'(rnd_lo);
                rnd_res.s = 1'b0;
            end
        end
    end

    always_comb begin
        err_res  = pidsc_pkg::sat_add(r_target, r_reading, 1'b1);
        diff_res = pidsc_pkg::sat_add(r_error, r_last_err, 1'b1);
        acc_res  = pidsc_pkg::sat_add(r_ctl, r_term, 1'b0);
        int_res  = pidsc_pkg::sat_add(r_int, r_term, 1'b0);
    end

    always_comb begin
        lim_pos = pidsc_pkg::t_val'({1'b0, i_cfg.i_limit});
        lim_neg = -lim_pos;
        if (r_int > lim_pos) begin
            lim_val = lim_pos;
        end else if (r_int < lim_neg) begin
            lim_val = lim_neg;
        end else begin
            lim_val = r_int;
        end
    end

    always_comb begin
        clamp_val = r_ctl;
        clamp_hit = 1'b0;
        if (i_cmd.en_min && clamp_val < i_cfg.out_min) begin
            clamp_val = i_cfg.out_min;
            clamp_hit = 1'b1;
        end
        if (i_cmd.en_max && clamp_val > i_cfg.out_max) begin
            clamp_val = i_cfg.out_max;
            clamp_hit = 1'b1;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_reading <= 1'b0;
            r_have_target  <= 1'b0;
            r_reading      <= '0;
            r_target       <= '0;
            r_int          <= '0;
            r_last_err     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.ld_reading) begin
                r_reading      <= i_speed_value;
                r_have_reading <= 1'b1;
            end
            if (i_cmd.ld_target) begin
                r_target      <= i_speed_value;
                r_have_target <= 1'b1;
            end
            if (i_cmd.op == pidsc_pkg::OP_INT_ADD) begin
                r_int <= int_res.v;
            end else if (i_cmd.op == pidsc_pkg::OP_INT_LIM) begin
                r_int <= lim_val;
            end
            if (i_cmd.op == pidsc_pkg::OP_OUT) begin
                r_last_err  <= r_error;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pidsc_pkg::OP_ERR: begin
                r_error <= err_res.v;
                r_sat   <= err_res.s;
                r_ctl   <= '0;
            end
            pidsc_pkg::OP_DIFF: begin
                r_term <= diff_res.v;
                r_sat  <= r_sat | diff_res.s;
            end
            pidsc_pkg::OP_MUL: begin
                r_prod <= pidsc_pkg::PW'(pidsc_pkg::mag(mul_a))
                        * pidsc_pkg::PW'(pidsc_pkg::mag(mul_b));
                r_neg  <= mul_a[pidsc_pkg::VW-1] ^ mul_b[pidsc_pkg::VW-1];
            end
            pidsc_pkg::OP_RND: begin
                r_term <= rnd_res.v;
                r_sat  <= r_sat | rnd_res.s;
            end
            pidsc_pkg::OP_ACC: begin
                r_ctl <= acc_res.v;
                r_sat <= r_sat | acc_res.s;
            end
            pidsc_pkg::OP_INT_ADD: begin
                r_sat <= r_sat | int_res.s;
            end
            pidsc_pkg::OP_CLAMP: begin
                r_ctl <= clamp_val;
                r_sat <= r_sat | clamp_hit;
            end
            pidsc_pkg::OP_OUT: begin
                r_out_ctl     <= r_ctl;
                r_out_clamped <= r_sat;
            end
            default: ;
        endcase
    end

    assign o_stat.have_both = r_have_reading && r_have_target;
    assign o_stat.out_free  = out_free;
    assign o_out_valid      = r_out_valid;
    assign o_control_value  = r_out_ctl;
    assign o_output_clamped = r_out_clamped;

endmodule

FILE: hdl/pid_speed_controller.sv
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_req_type, i_speed_value
// result    out        o_out_valid / i_out_ready  o_control_value, o_output_clamped
// config    in         psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// Reading, target, unused-code and early-tick requests leave the FSM in idle. A
// computed tick runs error, the enabled P, D and I terms, clamp and output-load
// steps before the next request is taken, with one shared 32x32 multiplier and a
// rounding step per product (the I term has two products). A result waits in the
// output register; the next request is taken meanwhile; output load waits while full.
// Reset is synchronous; it resets config, held state, last error and integral.
module pid_speed_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic signed [31:0]            i_speed_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_control_value,
    output logic                          o_output_clamped,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [pidsc_pkg::DATA_W-1:0]  pwdata,
    output logic [pidsc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    pidsc_pkg::t_cfg                 r_cfg;
    logic [pidsc_pkg::MASK_W-1:0]    r_mask;
    pidsc_pkg::t_cmd                 cmd;
    pidsc_pkg::t_stat                stat;
    pidsc_pkg::t_reg_idx             reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = pidsc_pkg::t_reg_idx'(paddr[pidsc_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp        <= '0;
            r_cfg.ki        <= '0;
            r_cfg.kd_scaled <= '0;
            r_cfg.dt_step   <= pidsc_pkg::DT_RESET;
            r_cfg.i_limit   <= '0;
            r_cfg.out_min   <= '0;
            r_cfg.out_max   <= '0;
            r_mask          <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                pidsc_pkg::REG_KP:      r_cfg.kp <= pwdata;
                pidsc_pkg::REG_KI:      r_cfg.ki <= pwdata;
                pidsc_pkg::REG_KD:      r_cfg.kd_scaled <= pwdata;
                pidsc_pkg::REG_DT:      r_cfg.dt_step <= pwdata[pidsc_pkg::DT_W-1:0];
                pidsc_pkg::REG_ILIM:    r_cfg.i_limit <= pwdata[pidsc_pkg::LIM_W-1:0];
                pidsc_pkg::REG_OUT_MIN: r_cfg.out_min <= pwdata;
                pidsc_pkg::REG_OUT_MAX: r_cfg.out_max <= pwdata;
                pidsc_pkg::REG_MASK:    r_mask <= pwdata[pidsc_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pidsc_pkg::REG_KP:      prdata = r_cfg.kp;
            pidsc_pkg::REG_KI:      prdata = r_cfg.ki;
            pidsc_pkg::REG_KD:      prdata = r_cfg.kd_scaled;
            pidsc_pkg::REG_DT:      prdata = pidsc_pkg::DATA_W'(r_cfg.dt_step);
            pidsc_pkg::REG_ILIM:    prdata = pidsc_pkg::DATA_W'(r_cfg.i_limit);
            pidsc_pkg::REG_OUT_MIN: prdata = r_cfg.out_min;
            pidsc_pkg::REG_OUT_MAX: prdata = r_cfg.out_max;
            pidsc_pkg::REG_MASK:    prdata = pidsc_pkg::DATA_W'(r_mask);
            default:                prdata = '0;
        endcase
    end

    pidsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_mask     (r_mask),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pidsc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (r_cfg),
        .i_speed_value    (i_speed_value),
        .i_out_ready      (i_out_ready),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_control_value  (o_control_value),
        .o_output_clamped (o_output_clamped)
    );

endmodule

FILE: sim/pid_speed_controller_tb.sv
`timescale 1ns / 100ps

module pid_speed_controller_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam longint VAL_HI = 64'sd2147483647;
    localparam longint VAL_LO = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]      code;
        pidsc_pkg::t_val speed;
    } t_speed_req;

    typedef struct {
        pidsc_pkg::t_val control;
        logic            clamped;
    } t_ctl_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = 2'd0;
    pidsc_pkg::t_val i_speed_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    pidsc_pkg::t_val o_control_value;
    logic        o_output_clamped;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pidsc_pkg::ADDR_W-1:0] paddr = '0;
    logic [pidsc_pkg::DATA_W-1:0] pwdata = '0;
    logic [pidsc_pkg::DATA_W-1:0] prdata;
    logic        pready;

    t_speed_req  pending_reqs[$];
    t_ctl_result expected_ctl[$];

    pidsc_pkg::t_val gain_p, gain_i, gain_d, bound_lo, bound_hi;
    logic [16:0] tick_dt;
    logic [30:0] integ_limit;
    logic [5:0]  term_mask;
    pidsc_pkg::t_val last_reading, last_target, integ_acc, prev_err;
    bit          reading_seen, target_seen;
    bit          tick_clamped;

    int  n_queued, n_accepted, n_results, n_settings, error_count, cycle_count;
    int  send_gap, recv_wait, hold_left;
    bit  send_steady, recv_steady;
    bit  hold_tog = 1'b0;
    bit  hold_seen;

    pid_speed_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_speed_value    (i_speed_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_control_value  (o_control_value),
        .o_output_clamped (o_output_clamped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic pidsc_pkg::t_val fit_width(longint v);
        if (v > VAL_HI) begin
            tick_clamped = 1'b1;
            return pidsc_pkg::VMAX;
        end
        if (v < VAL_LO) begin
            tick_clamped = 1'b1;
            return pidsc_pkg::VMIN;
        end
        return pidsc_pkg::t_val'(v);
    endfunction

    function automatic pidsc_pkg::t_val sum_clip(pidsc_pkg::t_val a, pidsc_pkg::t_val b,
                                                 bit subtract);
        longint s;
        s = subtract ? longint'(a) - longint'(b) : longint'(a) + longint'(b);
        return fit_width(s);
    endfunction

    // round half away from zero on the magnitude, then restore the sign
    function automatic pidsc_pkg::t_val fx_product(pidsc_pkg::t_val a, longint b);
        longint p, m;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = longint'(a) * b;
        m = (p < 0) ? -p : p;
        m = (m + 64'sd32768) >> pidsc_pkg::FB;
        if (neg) begin
            m = -m;
        end
        return fit_width(m);
    endfunction

    task automatic predict_request(logic [1:0] code, pidsc_pkg::t_val speed);
        pidsc_pkg::t_val err, term, ctl;
        t_ctl_result res;
        case (code)
            pidsc_pkg::REQ_READING: begin
                last_reading = speed;
                reading_seen = 1'b1;
            end
            pidsc_pkg::REQ_TARGET: begin
                last_target = speed;
                target_seen = 1'b1;
            end
            pidsc_pkg::REQ_TICK: begin
                if (reading_seen && target_seen) begin
                    tick_clamped = 1'b0;
                    ctl = '0;
                    err = sum_clip(last_target, last_reading, 1'b1);
                    if (term_mask[pidsc_pkg::EN_P]) begin
                        ctl = sum_clip(ctl, fx_product(gain_p, longint'(err)), 1'b0);
                    end
                    if (term_mask[pidsc_pkg::EN_D]) begin
                        term = sum_clip(err, prev_err, 1'b1);
                        ctl = sum_clip(ctl, fx_product(gain_d, longint'(term)), 1'b0);
                    end
                    if (term_mask[pidsc_pkg::EN_I]) begin
                        term = fx_product(err, longint'(tick_dt));
                        integ_acc = sum_clip(integ_acc, term, 1'b0);
                        if (term_mask[pidsc_pkg::EN_LIM]) begin
                            if (longint'(integ_acc) > longint'(integ_limit)) begin
                                integ_acc = pidsc_pkg::t_val'(integ_limit);
                            end else if (longint'(integ_acc) < -longint'(integ_limit)) begin
                                integ_acc = -pidsc_pkg::t_val'(integ_limit);
                            end
                        end
                        ctl = sum_clip(ctl, fx_product(gain_i, longint'(integ_acc)), 1'b0);
                    end
                    if (term_mask[pidsc_pkg::EN_MIN] && ctl < bound_lo) begin
                        ctl = bound_lo;
                        tick_clamped = 1'b1;
                    end
                    if (term_mask[pidsc_pkg::EN_MAX] && ctl > bound_hi) begin
                        ctl = bound_hi;
                        tick_clamped = 1'b1;
                    end
                    prev_err = err;
                    res.control = ctl;
                    res.clamped = tick_clamped;
                    expected_ctl.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result(pidsc_pkg::t_val got_ctl, logic got_clamped);
        t_ctl_result want;
        n_results++;
        if (expected_ctl.size() == 0) begin
            $error("unexpected result: control_value %0d output_clamped %0d",
                   got_ctl, got_clamped);
            error_count++;
        end else begin
            want = expected_ctl.pop_front();
            if (got_ctl !== want.control) begin
                $error("control_value: expected %0d, got %0d", want.control, got_ctl);
                error_count++;
            end
            if (got_clamped !== want.clamped) begin
                $error("output_clamped: expected %0d, got %0d", want.clamped, got_clamped);
                error_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pid_speed_controller_tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_speed_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_request(i_req_type, i_speed_value);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= nxt.code;
                    i_speed_value <= nxt.speed;
                    send_gap = send_steady ? 0 : $urandom_range(0, 6);
                    if ($urandom_range(0, 49) == 0) begin
                        send_steady = !send_steady;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (o_out_valid && i_out_ready) begin
                check_result(o_control_value, o_output_clamped);
                recv_wait = recv_steady ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 49) == 0) begin
                    recv_steady = !recv_steady;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(pidsc_pkg::t_reg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pidsc_pkg::REG_KP:      gain_p = data;
            pidsc_pkg::REG_KI:      gain_i = data;
            pidsc_pkg::REG_KD:      gain_d = data;
            pidsc_pkg::REG_DT:      tick_dt = data[16:0];
            pidsc_pkg::REG_ILIM:    integ_limit = data[30:0];
            pidsc_pkg::REG_OUT_MIN: bound_lo = data;
            pidsc_pkg::REG_OUT_MAX: bound_hi = data;
            pidsc_pkg::REG_MASK:    term_mask = data[5:0];
            default: ;
        endcase
    endtask

    task automatic write_gains(pidsc_pkg::t_val kp, pidsc_pkg::t_val ki, pidsc_pkg::t_val kd,
                               logic [16:0] dt, logic [30:0] ilim, pidsc_pkg::t_val lo,
                               pidsc_pkg::t_val hi, logic [5:0] mask);
        write_reg(pidsc_pkg::REG_KP, kp);
        write_reg(pidsc_pkg::REG_KI, ki);
        write_reg(pidsc_pkg::REG_KD, kd);
        write_reg(pidsc_pkg::REG_DT, {15'd0, dt});
        write_reg(pidsc_pkg::REG_ILIM, {1'b0, ilim});
        write_reg(pidsc_pkg::REG_OUT_MIN, lo);
        write_reg(pidsc_pkg::REG_OUT_MAX, hi);
        write_reg(pidsc_pkg::REG_MASK, {26'd0, mask});
        n_settings++;
    endtask

    task automatic queue_request(logic [1:0] code, pidsc_pkg::t_val speed);
        t_speed_req r;
        r.code = code;
        r.speed = speed;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    function automatic pidsc_pkg::t_val pick_speed();
        case ($urandom_range(0, 15))
            0:       return pidsc_pkg::VMAX;
            1:       return pidsc_pkg::VMIN;
            2, 3:    return pidsc_pkg::t_val'($urandom);
            default: return pidsc_pkg::t_val'($urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
        endcase
    endfunction

    function automatic pidsc_pkg::t_val pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return pidsc_pkg::VMAX;
            2:       return pidsc_pkg::VMIN;
            3:       return pidsc_pkg::t_val'($urandom);
            default: return pidsc_pkg::t_val'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [16:0] pick_dt();
        case ($urandom_range(0, 7))
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return 17'd65536;
            3:       return 17'($urandom_range(0, 131071));
            4:       return pidsc_pkg::DT_RESET;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0080_0000));
        endcase
    endfunction

    function automatic pidsc_pkg::t_val pick_bound();
        case ($urandom_range(0, 9))
            0:       return pidsc_pkg::VMIN;
            1:       return pidsc_pkg::VMAX;
            default: return pidsc_pkg::t_val'($urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
        endcase
    endfunction

    task automatic write_random_gains();
        pidsc_pkg::t_val lo, hi, tmp;
        logic [5:0] mask;
        lo = pick_bound();
        hi = pick_bound();
        if (lo > hi && $urandom_range(0, 3) != 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        mask = ($urandom_range(0, 2) == 0) ? 6'h3F : 6'($urandom_range(0, 63));
        write_gains(pick_gain(), pick_gain(), pick_gain(), pick_dt(), pick_limit(),
                    lo, hi, mask);
    endtask

    // mostly reading/target/tick triples so the integral and derivative build up
    task automatic queue_random_requests(int n);
        int left;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_request(pidsc_pkg::REQ_READING, pick_speed());
                queue_request(pidsc_pkg::REQ_TARGET, pick_speed());
                queue_request(pidsc_pkg::REQ_TICK, pidsc_pkg::t_val'($urandom));
                left -= 3;
            end else begin
                case ($urandom_range(0, 4))
                    0:       queue_request(pidsc_pkg::REQ_READING, pick_speed());
                    1:       queue_request(pidsc_pkg::REQ_TARGET, pick_speed());
                    2, 3:    queue_request(pidsc_pkg::REQ_TICK, pidsc_pkg::t_val'($urandom));
                    default: queue_request(REQ_UNUSED, pidsc_pkg::t_val'($urandom));
                endcase
                left--;
            end
        end
    endtask

    task automatic wait_idle();
        int spent;
        spent = 0;
        while ((n_accepted != n_queued || expected_ctl.size() != 0) && spent < 20000) begin
            @(posedge i_clk);
            spent++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        gain_p = '0;
        gain_i = '0;
        gain_d = '0;
        tick_dt = pidsc_pkg::DT_RESET;
        integ_limit = '0;
        bound_lo = '0;
        bound_hi = '0;
        term_mask = '0;
        last_reading = '0;
        last_target = '0;
        integ_acc = '0;
        prev_err = '0;
        reading_seen = 1'b0;
        target_seen = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_gains(pidsc_pkg::t_val'(32'h0001_0000), pidsc_pkg::t_val'(32'h0000_8000),
                    pidsc_pkg::t_val'(32'h0000_4000), pidsc_pkg::DT_RESET, 31'h000A_0000,
                    pidsc_pkg::t_val'(32'hFF9C_0000), pidsc_pkg::t_val'(32'h0064_0000),
                    6'h3F);
        // tick too early, unused code, still only a reading
        queue_request(pidsc_pkg::REQ_TICK, pidsc_pkg::t_val'(32'h1234_5678));
        queue_request(REQ_UNUSED, pidsc_pkg::t_val'(32'hFFFF_FFFF));
        queue_request(pidsc_pkg::REQ_READING, pidsc_pkg::t_val'(32'h0001_0000));
        queue_request(pidsc_pkg::REQ_TICK, '0);
        queue_request(pidsc_pkg::REQ_TARGET, pidsc_pkg::VMAX);
        queue_request(pidsc_pkg::REQ_TICK, pidsc_pkg::t_val'(32'hA5A5_A5A5));
        queue_request(pidsc_pkg::REQ_READING, pidsc_pkg::VMIN);
        queue_request(pidsc_pkg::REQ_TICK, pidsc_pkg::t_val'(32'h5A5A_5A5A));
        queue_request(pidsc_pkg::REQ_TARGET, pidsc_pkg::VMIN);
        queue_request(pidsc_pkg::REQ_READING, pidsc_pkg::VMAX);
        queue_request(pidsc_pkg::REQ_TICK, pidsc_pkg::VMIN);
        queue_request(pidsc_pkg::REQ_TICK, pidsc_pkg::VMAX);
        queue_request(pidsc_pkg::REQ_READING, '0);
        queue_request(pidsc_pkg::REQ_TARGET, '0);
        queue_request(pidsc_pkg::REQ_TICK, '0);
        queue_request(REQ_UNUSED, '0);
        queue_request(pidsc_pkg::REQ_TARGET, pidsc_pkg::t_val'(32'sd1));
        queue_request(pidsc_pkg::REQ_READING, pidsc_pkg::t_val'(-32'sd1));
        queue_request(pidsc_pkg::REQ_TICK, '0);
        queue_request(pidsc_pkg::REQ_TARGET, pidsc_pkg::t_val'(32'h0000_8000));
        queue_request(pidsc_pkg::REQ_TICK, '0);
        wait_idle();

        // crossed bounds, zero period, zero integral limit
        write_gains(pidsc_pkg::VMIN, pidsc_pkg::VMAX, pidsc_pkg::VMAX, 17'd0, '0,
                    pidsc_pkg::t_val'(32'h0032_0000), pidsc_pkg::t_val'(32'hFFCE_0000),
                    6'h3F);
        queue_random_requests(100);
        wait_idle();

        write_gains(pidsc_pkg::VMAX, pidsc_pkg::VMIN, pidsc_pkg::VMIN, 17'd65536, '1,
                    pidsc_pkg::VMIN, pidsc_pkg::VMAX, 6'h3F);
        queue_random_requests(100);
        wait_idle();

        write_gains(pick_gain(), pick_gain(), pick_gain(), pick_dt(), pick_limit(),
                    pick_bound(), pick_bound(), 6'h00);
        queue_random_requests(60);
        wait_idle();

        // hold the output side off so the request side backs up
        write_random_gains();
        hold_tog <= ~hold_tog;
        queue_random_requests(150);
        wait_idle();

        for (int ph = 0; ph < 11; ph++) begin
            write_random_gains();
            queue_random_requests(130);
            wait_idle();
        end

        if (expected_ctl.size() != 0) begin
            $error("%0d control results never arrived", expected_ctl.size());
            error_count++;
        end
        $display("covered %0d requests over %0d gain settings, %0d control results checked",
                 n_accepted, n_settings, n_results);
        $display("output side held off once for %0d cycles, %0d mismatches",
                 HOLD_CYCLES, error_count);
        if (error_count == 0) begin
            $display("pid_speed_controller_tb: done, clean");
        end else begin
            $display("pid_speed_controller_tb: done, errors");
        end
        $finish;
    end

endmodule
